/* hdl/mexp_pkg.sv */
// Shared widths and constants for the modular exponentiation block.
package mexp_pkg;
  localparam int MOD_W = 31;
  localparam int BASE_W = 32;
  localparam int EXP_WIDTH = 32;
  localparam int MUL_CNT_W = $clog2(MOD_W + 1);
  localparam int RED_CNT_W = $clog2(BASE_W + 1);
  localparam int EXP_CNT_W = $clog2(EXP_WIDTH + 1);
  localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(998244353);
  localparam logic [MOD_W-1:0] MODULUS_MIN = MOD_W'(2);
endpackage

/* hdl/mexp_in_if.sv */
// Input channel: base and signed exponent with valid/ready.
interface mexp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [mexp_pkg::BASE_W-1:0]           base_value;
  logic signed [mexp_pkg::EXP_WIDTH-1:0] exponent;
  modport source(output valid, base_value, exponent, input ready);
  modport sink(input valid, base_value, exponent, output ready);
endinterface

/* hdl/mexp_out_if.sv */
// Result channel: power result with valid/ready.
interface mexp_out_if;
  logic                       valid;
  logic                       ready;
  logic [mexp_pkg::MOD_W-1:0] power_result;
  modport source(output valid, power_result, input ready);
  modport sink(input valid, power_result, output ready);
endinterface

/* hdl/modular_exponentiation.sv */
// The base is first reduced modulo the modulus, then each exponent bit is handled by the
// two bit-serial modular multipliers, which square and multiply side by side.
// One transaction at a time: no new input is taken until the result is loaded into the
// output register. Negative exponents or a modulus below two give the result 0
// without reduction or multiplication.
// Synchronous active-low reset idles the block and sets the modulus to 998244353.
module modular_exponentiation (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [mexp_pkg::MOD_W-1:0] cfg_wdata,
  mexp_in_if.sink                    in_ch,
  mexp_out_if.source                 out_ch
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RED  = 4'b0010,
    S_MUL  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [mexp_pkg::MOD_W-1:0]       mod_r;
  logic [mexp_pkg::MOD_W-1:0]       acc_r, acc_nxt;
  logic [mexp_pkg::MOD_W-1:0]       sq_r, sq_nxt;
  logic [mexp_pkg::MOD_W-1:0]       res_r, res_nxt;
  logic [mexp_pkg::EXP_WIDTH-1:0]   e_r, e_nxt;
  logic [mexp_pkg::EXP_CNT_W-1:0]   ecnt_r, ecnt_nxt;
  logic [mexp_pkg::MOD_W-1:0]       out_data_r;
  logic                             out_valid_r;
  logic                             out_load;
  logic                             in_fire;
  logic                             red_start, red_done;
  logic [mexp_pkg::MOD_W-1:0]       red_val;
  logic                             mul_start;
  logic                             acc_done, sq_done, acc_busy, sq_busy;
  logic [mexp_pkg::MOD_W-1:0]       acc_p, sq_p;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign mul_start = (state_r == S_MUL) && !sq_busy && !sq_done;

  mexp_modred u_red (
    .clk(clk), .rst_n(rst_n), .start(red_start), .x(in_ch.base_value),
    .m(mod_r), .done(red_done), .r(red_val)
  );

  mexp_modmul u_mul_acc (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(acc_r), .b(sq_r),
    .m(mod_r), .done(acc_done), .busy(acc_busy), .p(acc_p)
  );

  mexp_modmul u_mul_sq (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(sq_r), .b(sq_r),
    .m(mod_r), .done(sq_done), .busy(sq_busy), .p(sq_p)
  );

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    sq_nxt    = sq_r;
    res_nxt   = res_r;
    e_nxt     = e_r;
    ecnt_nxt  = ecnt_r;
    red_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          e_nxt    = in_ch.exponent;
          ecnt_nxt = mexp_pkg::EXP_CNT_W'(mexp_pkg::EXP_WIDTH);
          if (mod_r < mexp_pkg::MODULUS_MIN || in_ch.exponent[mexp_pkg::EXP_WIDTH-1]) begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            red_start = 1'b1;
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        if (red_done) begin
          sq_nxt    = red_val;
          acc_nxt   = mexp_pkg::MOD_W'(1);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (sq_done) begin
          if (e_r[0]) begin
            acc_nxt = acc_p;
          end
          sq_nxt   = sq_p;
          e_nxt    = e_r >> 1;
          ecnt_nxt = ecnt_r - mexp_pkg::EXP_CNT_W'(1);
          if (ecnt_r == mexp_pkg::EXP_CNT_W'(1)) begin
            res_nxt   = e_r[0] ? acc_p : acc_r;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mod_r       <= mexp_pkg::MODULUS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        mod_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    sq_r   <= sq_nxt;
    res_r  <= res_nxt;
    e_r    <= e_nxt;
    ecnt_r <= ecnt_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.power_result = out_data_r;

  // Both multipliers start together and must finish in the same cycle.
  a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    acc_done == sq_done && acc_busy == sq_busy)
    else $error("multipliers out of step");

  // A loaded result is reduced below the modulus, unless the modulus is below two.
  a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (res_r < mod_r || mod_r < mexp_pkg::MODULUS_MIN))
    else $error("result not reduced");

  // No multiplication runs while the base is being reduced.
  a_red_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RED |-> !sq_busy)
    else $error("multiplier busy during reduction");

  // A result is only loaded when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("pending result overwritten");
endmodule

/* hdl/mexp_modred.sv */
// Bit-serial reduction of the base modulo the modulus, one base bit per cycle.
module mexp_modred (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mexp_pkg::BASE_W-1:0] x,
  input  logic [mexp_pkg::MOD_W-1:0]  m,
  output logic                        done,
  output logic [mexp_pkg::MOD_W-1:0]  r
);
  logic                           busy_r;
  logic                           done_r;
  logic [mexp_pkg::RED_CNT_W-1:0] cnt_r;
  logic [mexp_pkg::BASE_W-1:0]    x_r;
  logic [mexp_pkg::MOD_W-1:0]     r_r;
  logic [mexp_pkg::MOD_W:0]       t;
  logic [mexp_pkg::MOD_W:0]       t_red;

  // The remainder stays below m, so one subtract keeps it reduced.
  assign t = {r_r, x_r[mexp_pkg::BASE_W-1]};
  assign t_red = (t >= {1'b0, m}) ? t - {1'b0, m} : t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == mexp_pkg::RED_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= mexp_pkg::RED_CNT_W'(mexp_pkg::BASE_W);
      x_r   <= x;
      r_r   <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - mexp_pkg::RED_CNT_W'(1);
      x_r   <= {x_r[mexp_pkg::BASE_W-2:0], 1'b0};
      r_r   <= t_red[mexp_pkg::MOD_W-1:0];
    end
  end

  assign done = done_r;
  assign r = r_r;
endmodule

/* hdl/mexp_modmul.sv */
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
module mexp_modmul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mexp_pkg::MOD_W-1:0] a,
  input  logic [mexp_pkg::MOD_W-1:0] b,
  input  logic [mexp_pkg::MOD_W-1:0] m,
  output logic                       done,
  output logic                       busy,
  output logic [mexp_pkg::MOD_W-1:0] p
);
  logic                           busy_r;
  logic                           done_r;
  logic [mexp_pkg::MUL_CNT_W-1:0] cnt_r;
  logic [mexp_pkg::MOD_W-1:0]     a_r;
  logic [mexp_pkg::MOD_W-1:0]     b_r;
  logic [mexp_pkg::MOD_W-1:0]     r_r;
  logic [mexp_pkg::MOD_W+1:0]     t;
  logic [mexp_pkg::MOD_W+1:0]     t1;
  logic [mexp_pkg::MOD_W+1:0]     t2;
  logic [mexp_pkg::MOD_W+1:0]     m_x;

  // 2r + a stays below 3m, so two conditional subtracts reduce it.
  assign m_x = {2'b00, m};
  assign t = {1'b0, r_r, 1'b0}
           + (b_r[mexp_pkg::MOD_W-1] ? {2'b00, a_r} : '0);
  assign t1 = (t >= m_x) ? t - m_x : t;
  assign t2 = (t1 >= m_x) ? t1 - m_x : t1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == mexp_pkg::MUL_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= mexp_pkg::MUL_CNT_W'(mexp_pkg::MOD_W);
      a_r   <= a;
      b_r   <= b;
      r_r   <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - mexp_pkg::MUL_CNT_W'(1);
      b_r   <= {b_r[mexp_pkg::MOD_W-2:0], 1'b0};
      r_r   <= t2[mexp_pkg::MOD_W-1:0];
    end
  end

  assign done = done_r;
  assign busy = busy_r;
  assign p = r_r;
endmodule
